// ===== rtl/core/vap_pkg.sv =====
// Shared types and constants for the average intensity projection block.
// No dependencies; every other file imports this package.
package vap_pkg;

  localparam int MAX_SIDE    = 256;
  localparam int SIDE_BITS   = 8;
  localparam int SIZE_BITS   = 9;
  localparam int SAMPLE_BITS = 16;
  localparam int SUM_BITS    = 25;
  localparam int MAG_BITS    = 24;
  localparam int IDX_BITS    = 2 * SIDE_BITS;
  localparam int MEM_DEPTH   = MAX_SIDE * MAX_SIDE;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_BITS  = 2;
  localparam int Q_CNT_BITS  = 3;
  localparam int ADDR_BITS   = 5;
  localparam int DATA_BITS   = 32;
  localparam int CNT_BITS    = 5;

  localparam logic signed [SAMPLE_BITS-1:0] FLOOR_LEVEL = -16'sd500;

  typedef enum logic [2:0] {
    REG_AXIS_MODE    = 3'd0,
    REG_SIZE_X       = 3'd1,
    REG_SIZE_Y       = 3'd2,
    REG_SIZE_Z       = 3'd3,
    REG_SUB_RANGE_ON = 3'd4,
    REG_RANGE_FIRST  = 3'd5,
    REG_RANGE_END    = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  // one classified voxel, front to back
  typedef struct packed {
    logic [IDX_BITS-1:0]           idx;
    logic                          first;
    logic                          in_range;
    logic                          last;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          err;
    logic [SIZE_BITS-1:0]          len;
    logic                          done;
  } vap_entry_t;

  // finished pixel sum, accumulator to divider
  typedef struct packed {
    logic signed [SUM_BITS-1:0] sum;
    logic [SIZE_BITS-1:0]       len;
    logic                       err;
    logic [IDX_BITS-1:0]        idx;
    logic                       done;
  } div_req_t;

endpackage

// ===== rtl/core/vap_front.sv =====
// Front end: configuration registers, raster position counters and voxel
// classification into queue entries. Depends on vap_pkg.
module vap_front import vap_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_BITS-1:0]          paddr,
  input  logic [DATA_BITS-1:0]          pwdata,
  output logic [DATA_BITS-1:0]          prdata,
  output logic                          pready,
  input  logic                          push,
  input  logic signed [SAMPLE_BITS-1:0] voxel,
  output logic                          full,
  input  logic                          q_full,
  output logic                          q_push,
  output vap_entry_t                    q_entry
);

  logic [1:0]           axis_mode;
  logic [SIZE_BITS-1:0] size_x;
  logic [SIZE_BITS-1:0] size_y;
  logic [SIZE_BITS-1:0] size_z;
  logic                 sub_range_on;
  logic [SIZE_BITS-1:0] range_first;
  logic [SIZE_BITS-1:0] range_end;

  logic [SIDE_BITS-1:0] pos_x, pos_x_next;
  logic [SIDE_BITS-1:0] pos_y, pos_y_next;
  logic [SIDE_BITS-1:0] pos_z, pos_z_next;

  logic [SIZE_BITS-1:0] sx, sy, sz, asize, lo, hi;
  logic [SIDE_BITS-1:0] a, col, row;
  logic signed [SIZE_BITS:0] len;
  logic                 x_wrap, y_wrap, z_wrap;
  logic                 wr_en;
  reg_idx_t             reg_idx;

  function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] s);
    logic [SIZE_BITS-1:0] r;
    r = s;
    if (s == '0) r = SIZE_BITS'(1);
    else if (s > SIZE_BITS'(MAX_SIDE)) r = SIZE_BITS'(MAX_SIDE);
    return r;
  endfunction

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_mode    <= AXIS_X;
      size_x       <= SIZE_BITS'(MAX_SIDE);
      size_y       <= SIZE_BITS'(MAX_SIDE);
      size_z       <= SIZE_BITS'(MAX_SIDE);
      sub_range_on <= 1'b0;
      range_first  <= '0;
      range_end    <= SIZE_BITS'(MAX_SIDE);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_AXIS_MODE:    axis_mode    <= pwdata[1:0];
        REG_SIZE_X:       size_x       <= pwdata[SIZE_BITS-1:0];
        REG_SIZE_Y:       size_y       <= pwdata[SIZE_BITS-1:0];
        REG_SIZE_Z:       size_z       <= pwdata[SIZE_BITS-1:0];
        REG_SUB_RANGE_ON: sub_range_on <= pwdata[0];
        REG_RANGE_FIRST:  range_first  <= pwdata[SIZE_BITS-1:0];
        REG_RANGE_END:    range_end    <= pwdata[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_AXIS_MODE:    prdata = DATA_BITS'(axis_mode);
      REG_SIZE_X:       prdata = DATA_BITS'(size_x);
      REG_SIZE_Y:       prdata = DATA_BITS'(size_y);
      REG_SIZE_Z:       prdata = DATA_BITS'(size_z);
      REG_SUB_RANGE_ON: prdata = DATA_BITS'(sub_range_on);
      REG_RANGE_FIRST:  prdata = DATA_BITS'(range_first);
      REG_RANGE_END:    prdata = DATA_BITS'(range_end);
      default:          prdata = '0;
    endcase
  end

  // classification
  always_comb begin
    sx = eff_size(size_x);
    sy = eff_size(size_y);
    sz = eff_size(size_z);
    unique case (axis_mode)
      AXIS_X: begin
        a = pos_x; asize = sx; col = pos_y; row = pos_z;
      end
      AXIS_Y: begin
        a = pos_y; asize = sy; col = pos_x; row = pos_z;
      end
      default: begin
        a = pos_z; asize = sz; col = pos_x; row = pos_y;
      end
    endcase
    if (sub_range_on) begin
      lo = range_first;
      hi = (range_end < asize) ? range_end : asize;
    end else begin
      lo = '0;
      hi = asize;
    end
    len = $signed({1'b0, hi}) - $signed({1'b0, lo});

    x_wrap = ({1'b0, pos_x} + SIZE_BITS'(1)) >= sx;
    y_wrap = ({1'b0, pos_y} + SIZE_BITS'(1)) >= sy;
    z_wrap = ({1'b0, pos_z} + SIZE_BITS'(1)) >= sz;

    q_entry.idx      = {row, col};
    q_entry.first    = (a == '0);
    q_entry.in_range = ({1'b0, a} >= lo) && ({1'b0, a} < hi);
    q_entry.last     = ({1'b0, a} == (asize - SIZE_BITS'(1)));
    q_entry.sample   = (voxel < FLOOR_LEVEL) ? FLOOR_LEVEL : voxel;
    q_entry.err      = len[SIZE_BITS] || (len == '0);
    q_entry.len      = len[SIZE_BITS-1:0];
    q_entry.done     = x_wrap && y_wrap && z_wrap;
  end

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    pos_x_next = pos_x;
    pos_y_next = pos_y;
    pos_z_next = pos_z;
    if (q_push) begin
      if (x_wrap) begin
        pos_x_next = '0;
        if (y_wrap) begin
          pos_y_next = '0;
          pos_z_next = z_wrap ? '0 : pos_z + SIDE_BITS'(1);
        end else begin
          pos_y_next = pos_y + SIDE_BITS'(1);
        end
      end else begin
        pos_x_next = pos_x + SIDE_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      pos_z <= pos_z_next;
    end
  end

endmodule

// ===== rtl/core/vap_queue.sv =====
// Short queue of classified voxels between front end and accumulator.
// Depends on vap_pkg.
module vap_queue import vap_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  vap_entry_t din,
  input  logic       pop,
  output vap_entry_t dout,
  output logic       full,
  output logic       valid
);

  vap_entry_t            slots [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_BITS-1:0] count, count_next;

  assign full  = (count == Q_CNT_BITS'(Q_DEPTH));
  assign valid = (count != '0);
  assign dout  = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + Q_CNT_BITS'(1);
    else if (pop && !push) count_next = count - Q_CNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) wr_ptr <= wr_ptr + Q_PTR_BITS'(1);
      if (pop) rd_ptr <= rd_ptr + Q_PTR_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

endmodule

// ===== rtl/core/vap_accum.sv =====
// Back end accumulator: per-pixel sum memory with read-modify-write and
// write-to-read forwarding; hands finished sums to the divider. Depends on vap_pkg.
module vap_accum import vap_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  vap_entry_t q_entry,
  output logic       q_pop,
  input  logic       div_ready,
  output logic       div_start,
  output div_req_t   div_req
);

  logic signed [SUM_BITS-1:0] sums [MEM_DEPTH];
  logic signed [SUM_BITS-1:0] mem_q;
  logic signed [SUM_BITS-1:0] fwd_sum;
  logic signed [SUM_BITS-1:0] base, sum_now;
  logic [IDX_BITS-1:0]        fwd_idx;
  logic                       fwd_valid;
  logic                       w_valid;
  logic                       w_adv;
  vap_entry_t                 w;

  assign w_adv = w_valid && (!w.last || div_ready);
  assign q_pop = q_valid && (!w_valid || w_adv);

  always_comb begin
    if (w.first) base = '0;
    else if (fwd_valid && (fwd_idx == w.idx)) base = fwd_sum;
    else base = mem_q;
    sum_now = w.in_range ? base + SUM_BITS'(w.sample) : base;
  end

  always_ff @(posedge clk) begin
    if (q_pop) mem_q <= sums[q_entry.idx];
  end

  always_ff @(posedge clk) begin
    if (w_adv) sums[w.idx] <= sum_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid   <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (q_pop) w_valid <= 1'b1;
      else if (w_adv) w_valid <= 1'b0;
      if (w_adv) fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) w <= q_entry;
    if (w_adv) begin
      fwd_idx <= w.idx;
      fwd_sum <= sum_now;
    end
  end

  assign div_start    = w_adv && w.last;
  assign div_req.sum  = sum_now;
  assign div_req.len  = w.len;
  assign div_req.err  = w.err;
  assign div_req.idx  = w.idx;
  assign div_req.done = w.done;

endmodule

// ===== rtl/core/vap_div.sv =====
// Bit-serial signed-by-unsigned divider with the result register that
// drives the output queue interface. Depends on vap_pkg.
module vap_div import vap_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  div_req_t                      req,
  output logic                          ready,
  input  logic                          pop,
  output logic                          empty,
  output logic signed [SAMPLE_BITS-1:0] mean_value,
  output logic [SIDE_BITS-1:0]          pixel_col,
  output logic [SIDE_BITS-1:0]          pixel_row,
  output logic                          range_error,
  output logic                          image_done
);

  div_state_t state, state_next;

  logic [MAG_BITS-1:0]  work;
  logic [SIZE_BITS-1:0] rem;
  logic [SIZE_BITS-1:0] dvs;
  logic [SIZE_BITS:0]   rem_sh;
  logic [SIZE_BITS:0]   rem_diff;
  logic                 q_bit;
  logic [CNT_BITS-1:0]  cnt;
  logic                 neg;
  logic                 err;
  logic [IDX_BITS-1:0]  idx;
  logic                 done;
  logic [SUM_BITS-1:0]  mag;
  logic [SAMPLE_BITS-1:0] quo;
  logic                 out_valid;
  logic                 out_load;
  logic                 out_pop;

  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE: if (start) state_next = DIV_RUN;
      DIV_RUN:  if (cnt == CNT_BITS'(MAG_BITS - 1)) state_next = DIV_DONE;
      DIV_DONE: if (!out_valid || pop) state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    ready    = (state == DIV_IDLE);
    out_load = (state == DIV_DONE) && (!out_valid || pop);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= DIV_IDLE;
    else state <= state_next;
  end

  assign mag      = req.sum[SUM_BITS-1] ? -req.sum : req.sum;
  assign rem_sh   = {rem, work[MAG_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, dvs};
  assign q_bit    = (rem_sh >= {1'b0, dvs});
  assign quo      = work[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (start && ready) begin
      work <= mag[MAG_BITS-1:0];
      rem  <= '0;
      cnt  <= '0;
      dvs  <= req.len;
      neg  <= req.sum[SUM_BITS-1];
      err  <= req.err;
      idx  <= req.idx;
      done <= req.done;
    end else if (state == DIV_RUN) begin
      rem  <= q_bit ? rem_diff[SIZE_BITS-1:0] : rem_sh[SIZE_BITS-1:0];
      work <= {work[MAG_BITS-2:0], q_bit};
      cnt  <= cnt + CNT_BITS'(1);
    end
  end

  assign out_pop = pop && out_valid;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (out_pop) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (err) mean_value <= '0;
      else mean_value <= neg ? -$signed(quo) : $signed(quo);
      pixel_col   <= idx[SIDE_BITS-1:0];
      pixel_row   <= idx[IDX_BITS-1:SIDE_BITS];
      range_error <= err;
      image_done  <= done;
    end
  end

  assign empty = !out_valid;

endmodule

// ===== rtl/core/volume_average_projection_top.sv =====
// Top level of the average intensity projection block.
// Depends on vap_pkg, vap_front, vap_queue, vap_accum and vap_div.
//
// Voxels enter in raster order (x fastest) on push/full; one transaction
// per voxel. Results leave on empty/pop, one per projected pixel, when the
// pixel's last voxel along the chosen axis has been summed. The APB port
// sets axis, volume sizes and the optional slice range; write it only while
// the block is idle.
// Throughput: one voxel per cycle while full is low and voxels complete no
// pixel. A voxel that completes a pixel holds the accumulator until the
// bit-serial divider is free; the divider takes one result at a time, through
// load, 24 quotient bits and hand-off, and the four-entry queue lets the front
// keep taking voxels meanwhile. From accepted last voxel, a result passes the
// queue, the accumulator, the divider and the result register to the ports.
// Reset clears position counters, queue, divider and output register, and
// loads register defaults; the sum memory is not cleared, since each pixel's
// sum restarts at its first slice. When the receiver stops popping, the
// result register holds, then divider, accumulator and queue fill and
// full rises.
module volume_average_projection_top import vap_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_BITS-1:0]          paddr,
  input  logic [DATA_BITS-1:0]          pwdata,
  output logic [DATA_BITS-1:0]          prdata,
  output logic                          pready,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] voxel,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [SAMPLE_BITS-1:0] mean_value,
  output logic [SIDE_BITS-1:0]          pixel_col,
  output logic [SIDE_BITS-1:0]          pixel_row,
  output logic                          range_error,
  output logic                          image_done
);

  vap_entry_t in_entry;
  vap_entry_t q_entry;
  div_req_t   div_req;
  logic       q_full, q_push, q_pop, q_valid;
  logic       div_ready, div_start;

  vap_front u_front (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .push    (push),
    .voxel   (voxel),
    .full    (full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (in_entry)
  );

  vap_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (in_entry),
    .pop   (q_pop),
    .dout  (q_entry),
    .full  (q_full),
    .valid (q_valid)
  );

  vap_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .div_ready (div_ready),
    .div_start (div_start),
    .div_req   (div_req)
  );

  vap_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .req         (div_req),
    .ready       (div_ready),
    .pop         (pop),
    .empty       (empty),
    .mean_value  (mean_value),
    .pixel_col   (pixel_col),
    .pixel_row   (pixel_row),
    .range_error (range_error),
    .image_done  (image_done)
  );

endmodule

// ===== rtl/core/vap_checker.sv =====
// Port-level checks for the projection block, bound to the top level.
// Depends on vap_pkg and volume_average_projection_top.
module vap_checker import vap_pkg::*; (
  input logic                          clk,
  input logic                          rst,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic signed [SAMPLE_BITS-1:0] mean_value,
  input logic [SIDE_BITS-1:0]          pixel_col,
  input logic [SIDE_BITS-1:0]          pixel_row,
  input logic                          range_error,
  input logic                          image_done
);

  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && range_error) |-> (mean_value == '0))
    else $error("range error with nonzero mean");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(mean_value) && $stable(pixel_col)
                          && $stable(pixel_row) && $stable(range_error)
                          && $stable(image_done)))
    else $error("result changed while stalled");

  a_known: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !$isunknown({mean_value, pixel_col, pixel_row, range_error, image_done}))
    else $error("unknown bits on a waiting result");

endmodule

bind volume_average_projection_top vap_checker u_chk (.*);
